// ----- rtl/lir_pkg.sv -----
// ============================================================================
// lir_pkg: shared definitions for the linear interpolation resampler
// Default widths, queue sizes, register map and the command flag type.
// ============================================================================
`default_nettype none

package lir_pkg;

  // Default datapath widths
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int STEP_FRAC_BITS_DEF = 16;

  // Output numbering width (wraps)
  localparam int INDEX_W = 24;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = 1;
  localparam int CQ_LW    = 2;

  // Result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_LW    = 3;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_STEP = 3'd0;

  // Classification of one accepted sample
  typedef struct packed {
    logic last;   // final sample of the stream
    logic first;  // no stored sample precedes it
  } cmd_flags_t;

endpackage

`default_nettype wire

// ----- rtl/lir_front.sv -----
// ============================================================================
// lir_front: input acceptance and classification
// Accepts samples, tags each as first/last of its stream and holds them in a
// short command queue for the back end.
// ============================================================================
`default_nettype none

module lir_front #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  output logic                         full,
  input  wire signed [SAMPLE_BITS-1:0] in_sample,
  input  wire                          in_last,
  output logic                         cmd_valid,
  output logic signed [SAMPLE_BITS-1:0] cmd_sample,
  output lir_pkg::cmd_flags_t          cmd_flags,
  input  wire                          cmd_pop
);

  logic signed [SAMPLE_BITS-1:0] smp_mem [lir_pkg::CQ_DEPTH];
  lir_pkg::cmd_flags_t           flg_mem [lir_pkg::CQ_DEPTH];

  logic [lir_pkg::CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lir_pkg::CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lir_pkg::CQ_LW-1:0] cnt_r, cnt_nxt;
  logic                      have_prev_r, have_prev_nxt;
  logic                      acc;
  logic                      pop_ok;

  assign full      = (cnt_r == lir_pkg::CQ_LW'(lir_pkg::CQ_DEPTH));
  assign acc       = push && !full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd_sample = smp_mem[rd_ptr_r];
  assign cmd_flags  = flg_mem[rd_ptr_r];

  // Advance pointers and track whether a sample is stored in this stream
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cnt_nxt       = cnt_r;
    have_prev_nxt = have_prev_r;
    if (acc) begin
      wr_ptr_nxt    = wr_ptr_r + 1'b1;
      have_prev_nxt = !in_last;
    end
    if (pop_ok) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({acc, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  // Store the transfer with its classification
  always_ff @(posedge clk) begin
    if (acc) begin
      smp_mem[wr_ptr_r]       <= in_sample;
      flg_mem[wr_ptr_r].last  <= in_last;
      flg_mem[wr_ptr_r].first <= !have_prev_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lir_back.sv -----
// ============================================================================
// lir_back: interpolation sequencer and datapath
// Walks the output phase across each interval, one output per cycle while the
// result queue has room, through a registered multiplier and a rounding adder.
// ============================================================================
`default_nettype none

module lir_back #(
  parameter int SAMPLE_BITS    = lir_pkg::SAMPLE_BITS_DEF,
  parameter int STEP_FRAC_BITS = lir_pkg::STEP_FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [STEP_FRAC_BITS+3:0]          step,
  input  wire                               cmd_valid,
  input  wire signed [SAMPLE_BITS-1:0]      cmd_sample,
  input  lir_pkg::cmd_flags_t               cmd_flags,
  output logic                              cmd_pop,
  input  wire [lir_pkg::OQ_LW-1:0]          oq_level,
  output logic                              wr_en,
  output logic [SAMPLE_BITS-1:0]            wr_sample,
  output logic [lir_pkg::INDEX_W-1:0]       wr_index,
  output logic                              wr_run_last
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SFB    = STEP_FRAC_BITS;
  localparam int STEP_W = SFB + 4;
  localparam int PH_W   = SFB + 5;
  localparam int PR_W   = SB + SFB + 2;

  localparam logic [PH_W-1:0]         PH_ONE   = PH_W'(1) << SFB;
  localparam logic [STEP_W-1:0]       MIN_STEP = STEP_W'(1) << (SFB - 4);
  localparam logic signed [PR_W-1:0]  RND_HALF = PR_W'(1) << (SFB - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_REPEAT = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic signed [SB-1:0]       prev_r, prev_nxt;
  logic signed [SB-1:0]       cur_r, cur_nxt;
  logic                       last_r, last_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic [lir_pkg::INDEX_W-1:0] count_r, count_nxt;

  // Multiplier stage
  logic                        v1_r;
  logic signed [PR_W-1:0]      prod_r;
  logic signed [SB-1:0]        base_r;
  logic [lir_pkg::INDEX_W-1:0] idx_r;
  logic                        rl_r;

  logic                        iss;
  logic signed [SB:0]          iss_diff;
  logic [SFB-1:0]              iss_frac;
  logic                        iss_rl;
  logic [STEP_W-1:0]           step_eff;
  logic [PH_W-1:0]             ph_adv;
  logic [PH_W-1:0]             ph_sub_idle;
  logic [PH_W-1:0]             ph_sub_adv;
  logic                        can_iss;

  logic signed [PR_W-1:0]      rnd;
  logic signed [PR_W-1:0]      quo;
  logic signed [SB+1:0]        val;

  assign step_eff    = (step < MIN_STEP) ? MIN_STEP : step;
  assign ph_adv      = phase_r + PH_W'(step_eff);
  assign ph_sub_idle = phase_r - PH_ONE;
  assign ph_sub_adv  = ph_adv - PH_ONE;
  assign can_iss     = ((lir_pkg::OQ_LW+1)'(oq_level) + (lir_pkg::OQ_LW+1)'(v1_r))
                       < (lir_pkg::OQ_LW+1)'(lir_pkg::OQ_DEPTH);

  // Sequence dispatch, interpolation run and final-sample repeat run
  always_comb begin
    state_nxt = state_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    cmd_pop   = 1'b0;
    iss       = 1'b0;
    iss_diff  = '0;
    iss_frac  = phase_r[SFB-1:0];
    iss_rl    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cur_nxt  = cmd_sample;
          last_nxt = cmd_flags.last;
          if (cmd_flags.first) begin
            prev_nxt  = cmd_sample;
            phase_nxt = '0;
            state_nxt = cmd_flags.last ? ST_REPEAT : ST_IDLE;
          end else if (phase_r < PH_ONE) begin
            state_nxt = ST_INTERP;
          end else begin
            prev_nxt = cmd_sample;
            if (cmd_flags.last && !(ph_sub_idle < PH_ONE)) begin
              phase_nxt = '0;
              count_nxt = '0;
            end else begin
              phase_nxt = ph_sub_idle;
              state_nxt = cmd_flags.last ? ST_REPEAT : ST_IDLE;
            end
          end
        end
      end
      ST_INTERP: begin
        if (can_iss) begin
          iss       = 1'b1;
          iss_diff  = (SB+1)'(cur_r) - (SB+1)'(prev_r);
          count_nxt = count_r + 1'b1;
          if (ph_adv < PH_ONE) begin
            phase_nxt = ph_adv;
          end else begin
            prev_nxt = cur_r;
            if (last_r && (ph_sub_adv < PH_ONE)) begin
              phase_nxt = ph_sub_adv;
              state_nxt = ST_REPEAT;
            end else if (last_r) begin
              iss_rl    = 1'b1;
              phase_nxt = '0;
              count_nxt = '0;
              state_nxt = ST_IDLE;
            end else begin
              iss_rl    = 1'b1;
              phase_nxt = ph_sub_adv;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_REPEAT: begin
        if (can_iss) begin
          iss       = 1'b1;
          count_nxt = count_r + 1'b1;
          if (ph_adv < PH_ONE) begin
            phase_nxt = ph_adv;
          end else begin
            iss_rl    = 1'b1;
            phase_nxt = '0;
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      prev_r  <= '0;
      cur_r   <= '0;
      last_r  <= 1'b0;
      phase_r <= '0;
      count_r <= '0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      v1_r    <= iss;
    end
  end

  // Register the product of difference and fraction
  always_ff @(posedge clk) begin
    if (iss) begin
      prod_r <= PR_W'(iss_diff) * PR_W'($signed({1'b0, iss_frac}));
      base_r <= prev_r;
      idx_r  <= count_r;
      rl_r   <= iss_rl;
    end
  end

  // Round to nearest (ties upward) and add the base sample
  assign rnd = prod_r + RND_HALF;
  assign quo = rnd >>> SFB;
  assign val = (SB+2)'(base_r) + quo[SB+1:0];

  assign wr_en       = v1_r;
  assign wr_sample   = val[SB-1:0];
  assign wr_index    = idx_r;
  assign wr_run_last = rl_r;

endmodule

`default_nettype wire

// ----- rtl/lir_outq.sv -----
// ============================================================================
// lir_outq: result queue
// Holds finished results until the consumer pops them.
// ============================================================================
`default_nettype none

module lir_outq #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [SAMPLE_BITS-1:0]        wr_sample,
  input  wire [lir_pkg::INDEX_W-1:0]   wr_index,
  input  wire                          wr_run_last,
  output logic [lir_pkg::OQ_LW-1:0]    level,
  output logic                         empty,
  input  wire                          pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic [lir_pkg::INDEX_W-1:0]  out_output_index,
  output logic                         out_run_last
);

  logic [SAMPLE_BITS-1:0]      smp_mem [lir_pkg::OQ_DEPTH];
  logic [lir_pkg::INDEX_W-1:0] idx_mem [lir_pkg::OQ_DEPTH];
  logic                        rl_mem  [lir_pkg::OQ_DEPTH];

  logic [lir_pkg::OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [lir_pkg::OQ_LW-1:0] cnt_r, cnt_nxt;
  logic                      rd_ok;

  assign empty = (cnt_r == '0);
  assign level = cnt_r;
  assign rd_ok = pop && !empty;

  assign out_sample_out   = $signed(smp_mem[rd_ptr_r]);
  assign out_output_index = idx_mem[rd_ptr_r];
  assign out_run_last     = rl_mem[rd_ptr_r];

  // Track occupancy
  always_comb begin
    case ({wr_en, rd_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Store results; the producer never writes while the queue is full
  always_ff @(posedge clk) begin
    if (wr_en) begin
      smp_mem[wr_ptr_r] <= wr_sample;
      idx_mem[wr_ptr_r] <= wr_index;
      rl_mem[wr_ptr_r]  <= wr_run_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/linear_interp_resampler.sv -----
// Throughput: the back sequencer pops each sample in its idle state, then issues
//   one result per cycle while the result queue has room, up to 32 per sample, through the single multiplier.
// Reset: synchronous, active low; clears queues and stream state and sets step
//   to 3.0.
// ============================================================================
// linear_interp_resampler: streaming linear-interpolation resampler
// Front end classifies samples into a command queue; back end interpolates
// outputs at a programmable Q4.16 step into a result queue.
// ============================================================================
`default_nettype none

module linear_interp_resampler #(
  parameter int SAMPLE_BITS    = lir_pkg::SAMPLE_BITS_DEF,
  parameter int STEP_FRAC_BITS = lir_pkg::STEP_FRAC_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // Input channel
  input  wire                            push,
  output logic                           full,
  input  wire signed [SAMPLE_BITS-1:0]   in_sample,
  input  wire                            in_last,
  // Result channel
  output logic                           empty,
  input  wire                            pop,
  output logic signed [SAMPLE_BITS-1:0]  out_sample_out,
  output logic [lir_pkg::INDEX_W-1:0]    out_output_index,
  output logic                           out_run_last,
  // Configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [lir_pkg::CFG_AW-1:0]      paddr,
  input  wire [lir_pkg::CFG_DW-1:0]      pwdata,
  output logic [lir_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int STEP_W = STEP_FRAC_BITS + 4;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3) << STEP_FRAC_BITS;

  logic [STEP_W-1:0]           step_r;
  logic                        cmd_valid;
  logic signed [SAMPLE_BITS-1:0] cmd_sample;
  lir_pkg::cmd_flags_t         cmd_flags;
  logic                        cmd_pop;
  logic [lir_pkg::OQ_LW-1:0]   oq_level;
  logic                        wr_en;
  logic [SAMPLE_BITS-1:0]      wr_sample;
  logic [lir_pkg::INDEX_W-1:0] wr_index;
  logic                        wr_run_last;

  // Step register
  assign pready = 1'b1;
  assign prdata = (paddr == lir_pkg::ADDR_STEP) ? lir_pkg::CFG_DW'(step_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == lir_pkg::ADDR_STEP)) begin
      step_r <= pwdata[STEP_W-1:0];
    end
  end

  lir_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_sample (in_sample),
    .in_last   (in_last),
    .cmd_valid (cmd_valid),
    .cmd_sample(cmd_sample),
    .cmd_flags (cmd_flags),
    .cmd_pop   (cmd_pop)
  );

  lir_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .STEP_FRAC_BITS(STEP_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step_r),
    .cmd_valid  (cmd_valid),
    .cmd_sample (cmd_sample),
    .cmd_flags  (cmd_flags),
    .cmd_pop    (cmd_pop),
    .oq_level   (oq_level),
    .wr_en      (wr_en),
    .wr_sample  (wr_sample),
    .wr_index   (wr_index),
    .wr_run_last(wr_run_last)
  );

  lir_outq #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr_en           (wr_en),
    .wr_sample       (wr_sample),
    .wr_index        (wr_index),
    .wr_run_last     (wr_run_last),
    .level           (oq_level),
    .empty           (empty),
    .pop             (pop),
    .out_sample_out  (out_sample_out),
    .out_output_index(out_output_index),
    .out_run_last    (out_run_last)
  );

endmodule

`default_nettype wire

// ----- rtl/lir_checker.sv -----
// ============================================================================
// lir_checker: port-level checks for the resampler
// Watches the result channel and configuration port over time.
// ============================================================================
`default_nettype none

module lir_checker #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           empty,
  input wire                           full,
  input wire                           pop,
  input wire signed [SAMPLE_BITS-1:0]  out_sample_out,
  input wire [lir_pkg::INDEX_W-1:0]    out_output_index,
  input wire                           out_run_last,
  input wire                           pready
);

  // Reset leaves the result queue empty and the input queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_sample_out) && $stable(out_output_index)
                          && $stable(out_run_last)))
    else $error("waiting result changed");

  // Consecutive transfers number outputs in order, or restart a stream
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) ##1 (pop && !empty) |->
      ((out_output_index == lir_pkg::INDEX_W'($past(out_output_index) + 1'b1))
       || (out_output_index == '0)))
    else $error("output index out of sequence");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind linear_interp_resampler lir_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lir_checker (.*);

`default_nettype wire

// ----- sim/tb_linear_interp_resampler.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_linear_interp_resampler: self-checking bench for the resampler
// Queues sample streams through a clocked driver and collects results in a
// clocked monitor. A local predictor rebuilds every output, interpolated or repeated, from
// each accepted sample and the current step, and the monitor compares each
// result with the oldest prediction. The step register is rewritten over APB
// between phases, covering the clamp below 1/16, unity and the largest step.
// ============================================================================

module tb_linear_interp_resampler;

  localparam int SMP_W = lir_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W = lir_pkg::STEP_FRAC_BITS_DEF;
  localparam int STEP_W = 20;
  localparam int unsigned ONE_POS = 1 << FRAC_W;
  localparam int unsigned MIN_STEP = ONE_POS >> 4;
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd196608;
  localparam int MAX_OUTS = 32;
  localparam int MAX_IDLE = 18;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 310;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    lst;
  } sample_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]     smp;
    logic [lir_pkg::INDEX_W-1:0] idx;
    logic                        fin;
  } out_item_t;

  // Clock, reset and block inputs
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic signed [SMP_W-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lir_pkg::CFG_AW-1:0] paddr = '0;
  logic [lir_pkg::CFG_DW-1:0] pwdata = '0;

  // Block outputs
  logic full;
  logic empty;
  logic signed [SMP_W-1:0] out_sample_out;
  logic [lir_pkg::INDEX_W-1:0] out_output_index;
  logic out_run_last;
  logic [lir_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // Stimulus and expectation stores
  sample_item_t pending_samples[$];
  out_item_t expected_outputs[$];
  int err_cnt = 0;

  // Predicted stream state and step register
  logic [STEP_W-1:0] step_reg = STEP_RESET;
  logic signed [SMP_W-1:0] prev_smp = '0;
  bit have_prev = 1'b0;
  int unsigned phase_pos = 0;
  logic [lir_pkg::INDEX_W-1:0] out_count = '0;

  // Idle control shared between the stimulus and the two clocked sides
  bit src_fast = 1'b0;
  bit snk_fast = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done;
  int unsigned gap_left;
  int unsigned rcv_wait;
  int unsigned hold_left;
  logic push_nxt;
  logic pop_nxt;
  sample_item_t next_item;
  out_item_t exp_o;

  linear_interp_resampler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .empty            (empty),
    .pop              (pop),
    .out_sample_out   (out_sample_out),
    .out_output_index (out_output_index),
    .out_run_last     (out_run_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // prev + frac*(cur-prev), rounded to nearest with ties upward
  function automatic logic signed [SMP_W-1:0] interpolate(
    input logic signed [SMP_W-1:0] a,
    input logic signed [SMP_W-1:0] b,
    input int unsigned frac
  );
    longint acc;
    longint res;
    acc = (longint'(b) - longint'(a)) * longint'(frac) + longint'(ONE_POS / 2);
    res = longint'(a) + (acc >>> FRAC_W);
    return res[SMP_W-1:0];
  endfunction

  // Work out every output caused by one accepted sample
  task automatic resample_input(input logic signed [SMP_W-1:0] cur, input logic lst);
    out_item_t batch[$];
    out_item_t o;
    int unsigned adv;
    adv = (step_reg < MIN_STEP) ? MIN_STEP : int'(step_reg);
    if (!have_prev) begin
      phase_pos = 0;
    end else begin
      while (phase_pos < ONE_POS && batch.size() < MAX_OUTS) begin
        o.smp = interpolate(prev_smp, cur, phase_pos);
        o.idx = out_count;
        o.fin = 1'b0;
        batch.push_back(o);
        out_count = out_count + 1'b1;
        phase_pos += adv;
      end
      phase_pos -= ONE_POS;
    end
    prev_smp = cur;
    have_prev = 1'b1;
    // Flush the tail of the final sample, then restart the stream
    if (lst) begin
      while (phase_pos < ONE_POS && batch.size() < MAX_OUTS) begin
        o.smp = cur;
        o.idx = out_count;
        o.fin = 1'b0;
        batch.push_back(o);
        out_count = out_count + 1'b1;
        phase_pos += adv;
      end
      prev_smp = '0;
      have_prev = 1'b0;
      phase_pos = 0;
      out_count = '0;
    end
    if (batch.size() != 0) batch[batch.size()-1].fin = 1'b1;
    foreach (batch[i]) expected_outputs.push_back(batch[i]);
  endtask

  function automatic int unsigned draw_gap(input bit fast);
    if (fast || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 32) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input logic [SMP_W-1:0] smp, input logic lst);
    sample_item_t it;
    it.smp = smp;
    it.lst = lst;
    pending_samples.push_back(it);
  endtask

  // Write the step register with a setup and an access phase
  task automatic write_step(input logic [STEP_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lir_pkg::ADDR_STEP;
    pwdata <= {12'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    step_reg = val;
  endtask

  // Hold until the sender is drained and every prediction has been matched
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_samples.size() != 0 || push || expected_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: offer queued samples, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      push_nxt = push;
      if (push && !full) begin
        resample_input(in_sample, in_last);
        push_nxt = 1'b0;
        gap_left = draw_gap(src_fast);
      end
      if (!push_nxt) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_samples.size() != 0) begin
          next_item = pending_samples.pop_front();
          in_sample <= next_item.smp;
          in_last <= next_item.lst;
          push_nxt = 1'b1;
        end
      end
      push <= push_nxt;
    end
  end

  // Receiver: pop results and compare with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      rcv_wait = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      pop_nxt = pop;
      if (pop && !empty) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t ERROR: unexpected result, expected none, got sample %0d index %0d last %0b",
                   $time, out_sample_out, out_output_index, out_run_last);
          err_cnt++;
        end else begin
          exp_o = expected_outputs.pop_front();
          if (out_sample_out !== exp_o.smp) begin
            $display("%0t ERROR: sample_out expected %0d, got %0d",
                     $time, exp_o.smp, out_sample_out);
            err_cnt++;
          end
          if (out_output_index !== exp_o.idx) begin
            $display("%0t ERROR: output_index expected %0d, got %0d",
                     $time, exp_o.idx, out_output_index);
            err_cnt++;
          end
          if (out_run_last !== exp_o.fin) begin
            $display("%0t ERROR: run_last expected %0b, got %0b",
                     $time, exp_o.fin, out_run_last);
            err_cnt++;
          end
        end
        rcv_wait = draw_gap(snk_fast);
        if (rcv_wait != 0) pop_nxt = 1'b0;
      end else if (!pop) begin
        if (hold_left != 0) hold_left--;
        else if (rcv_wait != 0) rcv_wait--;
        else pop_nxt = 1'b1;
      end
      // Back-pressure: stop popping for a long stretch once requested
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        pop_nxt = 1'b0;
      end
      pop <= pop_nxt;
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int rnd_cnt;
    int phase_no;
    int len;
    logic [STEP_W-1:0] st;
    rnd_cnt = 0;
    phase_no = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample stream at the reset step of 3.0
    queue_sample(16'h7fff, 1'b1);
    // Full-scale swings with a step above one
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h7fff, 1'b0);
    queue_sample(16'd100, 1'b0);
    queue_sample(16'(-5), 1'b1);
    wait_quiet();

    // Zero step clamps to 1/16: the last sample yields the maximum count
    write_step('0);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h7fff, 1'b0);
    queue_sample(16'h8000, 1'b1);
    wait_quiet();
    write_step(STEP_W'(MIN_STEP - 1));
    queue_sample(16'h1234, 1'b1);
    wait_quiet();

    // Half step lands on rounding ties in both directions
    write_step(STEP_W'(ONE_POS / 2));
    queue_sample(16'd0, 1'b0);
    queue_sample(16'd1, 1'b0);
    queue_sample(16'd0, 1'b0);
    queue_sample(16'hffff, 1'b0);
    queue_sample(16'h8000, 1'b1);
    wait_quiet();

    // Largest step: most intervals hold no output
    write_step('1);
    queue_sample(16'd7, 1'b0);
    queue_sample(16'(-7), 1'b0);
    queue_sample(16'd1000, 1'b0);
    queue_sample(16'd2000, 1'b0);
    queue_sample(16'd30000, 1'b1);
    wait_quiet();

    // Unity step, then change the step while the stream is open
    write_step(STEP_W'(ONE_POS));
    queue_sample(16'd10, 1'b0);
    queue_sample(16'(-10), 1'b0);
    queue_sample(16'd20, 1'b0);
    wait_quiet();
    write_step(STEP_W'(MIN_STEP));
    queue_sample(16'h7fff, 1'b0);
    queue_sample(16'h8000, 1'b1);
    wait_quiet();

    // Random phases of streams under varying steps and idling
    while (rnd_cnt < RANDOM_ITEMS) begin
      phase_no++;
      src_fast = ($urandom_range(0, 3) == 0);
      snk_fast = ($urandom_range(0, 3) == 0);
      if (phase_no == 3) begin
        // Fill the block while the receiver holds off
        write_step(STEP_W'(MIN_STEP));
        src_fast = 1'b1;
        hold_req = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: st = STEP_W'($urandom_range(0, MIN_STEP - 1));
          1: st = STEP_W'(MIN_STEP);
          2: st = '1;
          3: st = STEP_W'($urandom_range(MIN_STEP, ONE_POS));
          4: st = STEP_W'($urandom_range(ONE_POS, 4 * ONE_POS));
          default: st = STEP_W'($urandom);
        endcase
        write_step(st);
      end
      len = $urandom_range(4, 30);
      repeat (len) begin
        queue_sample(rand_sample(), $urandom_range(0, 9) == 0);
        rnd_cnt++;
      end
      wait_quiet();
    end

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
